### rtl/core/cuwm_pkg.sv
// shared types and constants of the checked unified word memory
package cuwm_pkg;

  localparam int unsigned MemWords = 1024;
  localparam int unsigned AddrW    = $clog2(MemWords);
  localparam int unsigned LimW     = 11;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned IdxW     = 30;

  localparam logic [2:0]      DrainSteps     = 3'd6;
  localparam logic [LimW-1:0] TextEndReset   = 11'd256;
  localparam logic [LimW-1:0] DataStartReset = 11'd256;
  localparam logic [LimW-1:0] DataEndReset   = 11'd1024;

  typedef enum logic [1:0] {
    ActFetch   = 2'd0,
    ActRead    = 2'd1,
    ActWrite   = 2'd2,
    ActPreload = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StsContinue  = 3'd0,
    StsTerminate = 3'd1,
    StsImemOvf   = 3'd2,
    StsDmemOvf   = 3'd3,
    StsUnaligned = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RegTextEnd   = 2'd0,
    RegDataStart = 2'd1,
    RegDataEnd   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] addr;
    logic [31:0] wr_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] rd_word;
    logic        read_valid;
    logic [2:0]  status_code;
  } out_item_t;

  typedef struct packed {
    logic [LimW-1:0] text_end;
    logic [LimW-1:0] data_start;
    logic [LimW-1:0] data_end;
  } cfg_t;

endpackage

### rtl/core/cuwm_ram.sv
// generic synchronous ram, one write port, one registered read port
module cuwm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/cuwm_cfg.sv
// apb configuration registers of the checked unified word memory
module cuwm_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cuwm_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output cuwm_pkg::cfg_t               cfg_o
);
  import cuwm_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        RegTextEnd:   cfg_d.text_end   = pwdata[LimW-1:0];
        RegDataStart: cfg_d.data_start = pwdata[LimW-1:0];
        RegDataEnd:   cfg_d.data_end   = pwdata[LimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegTextEnd:   prdata = 32'(cfg_q.text_end);
      RegDataStart: prdata = 32'(cfg_q.data_start);
      RegDataEnd:   prdata = 32'(cfg_q.data_end);
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_end   <= TextEndReset;
      cfg_q.data_start <= DataStartReset;
      cfg_q.data_end   <= DataEndReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/checked_unified_word_memory.sv
// checked unified word memory: bounds-checked instruction and data word store
//
// one input channel (in_valid_i/in_ready_o, in_data_i) carries fetch, data read,
// data write and preload beats; one output channel (out_valid_o/out_ready_i,
// out_data_o) returns exactly one result beat per input beat, in order.
// limits are set through the apb port: text_end at 0x0, data_start at 0x4,
// data_end at 0x8; the user must see that they are written only while no beat
// is in flight, the block does not enforce it. the accept cycle of an item
// issues the store read; the access state then checks the address, writes
// back and loads the output register once it is free; the input stays closed
// until the item is done. after reset a clearing pass zeroes all 1024 words
// of the store, one word a cycle; in_ready_o stays low during it, apb
// writes are still taken. status and drain count reset to continue and zero.
// a stalled receiver holds the result in the output register; one more item
// may be accepted meanwhile and waits for the register to free up.
module checked_unified_word_memory (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cuwm_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cuwm_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cuwm_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import cuwm_pkg::*;

  typedef enum logic [2:0] {
    FsmClear  = 3'b001,
    FsmIdle   = 3'b010,
    FsmAccess = 3'b100
  } fsm_e;

  fsm_e       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  in_item_t   item_q;
  out_item_t  out_q, out_d;
  logic       out_valid_q, out_valid_d;
  logic [2:0] status_q, status_d;
  logic [2:0] drain_q, drain_d;
  cfg_t       cfg;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic             ram_re;
  logic [31:0]      ram_rdata;

  logic             in_fire;
  logic             fire;
  logic [IdxW-1:0]  idx;
  logic             aligned;
  logic             imem_bad;
  logic             dmem_bad;
  logic [IdxW-1:0]  in_idx;

  cuwm_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  cuwm_ram #(
    .Width (32),
    .Depth (MemWords)
  ) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (in_idx[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == FsmIdle);
  assign in_fire    = in_valid_i & in_ready_o;
  assign in_idx     = in_data_i.addr[31:2];
  assign ram_re     = in_fire;

  assign idx      = item_q.addr[31:2];
  assign aligned  = (item_q.addr[1:0] == 2'b00);
  assign imem_bad = (idx >= IdxW'(cfg.text_end)) || (idx >= IdxW'(MemWords));
  assign dmem_bad = (idx < IdxW'(cfg.data_start)) || (idx >= IdxW'(cfg.data_end)) ||
                    (idx >= IdxW'(MemWords));
  assign fire     = (state_q == FsmAccess) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    status_d    = status_q;
    drain_d     = drain_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = idx[AddrW-1:0];
    ram_wdata   = item_q.wr_word;

    case (state_q)
      FsmClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 32'd0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(MemWords - 1)) begin
          state_d = FsmIdle;
        end
      end
      FsmIdle: begin
        if (in_fire) begin
          state_d = FsmAccess;
        end
      end
      FsmAccess: begin
        if (fire) begin
          out_d.rd_word    = 32'd0;
          out_d.read_valid = 1'b0;
          case (action_e'(item_q.action))
            ActFetch: begin
              if (drain_q != 3'd0) begin
                drain_d = drain_q - 3'd1;
                if (drain_q == 3'd1) begin
                  status_d = StsTerminate;
                end
              end else if (!aligned) begin
                status_d = StsUnaligned;
              end else if (imem_bad) begin
                status_d = StsImemOvf;
              end else begin
                out_d.rd_word    = ram_rdata;
                out_d.read_valid = 1'b1;
                if (ram_rdata == 32'd0) begin
                  drain_d = DrainSteps;
                end
              end
            end
            ActRead, ActWrite: begin
              if (!aligned) begin
                status_d = StsUnaligned;
              end else if (dmem_bad) begin
                status_d = StsDmemOvf;
              end else if (action_e'(item_q.action) == ActWrite) begin
                ram_we = 1'b1;
              end else begin
                out_d.rd_word    = ram_rdata;
                out_d.read_valid = 1'b1;
              end
            end
            ActPreload: begin
              ram_we    = 1'b1;
              ram_waddr = item_q.addr[AddrW-1:0];
            end
            default: ;
          endcase
          out_d.status_code = status_d;
          out_valid_d       = 1'b1;
          state_d           = FsmIdle;
        end
      end
      default: begin
        state_d = FsmClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FsmClear;
      clr_q       <= '0;
      status_q    <= StsContinue;
      drain_q     <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      status_q    <= status_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/cuwm_checker.sv
// port-level checker of the checked unified word memory and its bind
module cuwm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cuwm_pkg::out_item_t out_data_o
);
  import cuwm_pkg::*;

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // one item in flight: no accept in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on back-to-back cycles");

  // a beat without a word carries zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.read_valid |-> out_data_o.rd_word == 32'd0)
    else $error("rd_word nonzero without read_valid");

endmodule

bind checked_unified_word_memory cuwm_checker u_cuwm_checker (.*);
